// ===== rtl/msscan_pkg.sv =====
// Shared types and constants for the minimum-tracking stack.
`timescale 1ns / 1ps

package msscan_pkg;

  // Field widths of one beat on either side
  localparam int OP_BITS      = 2;
  localparam int VALUE_BITS   = 32;
  localparam int STATUS_BITS  = 2;
  localparam int S_TDATA_BITS = 40;
  localparam int M_TDATA_BITS = 40;

  // Field positions inside s_tdata and m_tdata
  localparam int OP_LSB     = 0;
  localparam int VALUE_LSB  = OP_BITS;
  localparam int STATUS_LSB = 0;
  localparam int RESULT_LSB = STATUS_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_MIN  = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Port controls from the sequencer to the entry memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/msscan_ram.sv =====
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module msscan_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  msscan_pkg::mem_ctl_t     mem_ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read on request; hold the last read word otherwise
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/msscan_ctrl.sv =====
// Sequencer: stack pointer, pop readback, minimum scan and the result register.
`timescale 1ns / 1ps

module msscan_ctrl #(
  parameter int DEPTH     = 128,
  parameter int WORD_BITS = 32,
  parameter int STORE_BITS = (WORD_BITS < msscan_pkg::VALUE_BITS) ? WORD_BITS
                                                                  : msscan_pkg::VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [msscan_pkg::S_TDATA_BITS-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [msscan_pkg::M_TDATA_BITS-1:0] m_tdata,
  output msscan_pkg::mem_ctl_t                mem_ctl,
  output logic [$clog2(DEPTH)-1:0]            wr_addr,
  output logic [STORE_BITS-1:0]               wr_data,
  output logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic [STORE_BITS-1:0]               rd_data
);

  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN,
    S_SEND
  } state_t;

  state_t                                  state;
  logic [CNT_BITS-1:0]                     count;
  logic [CNT_BITS-1:0]                     idx;
  logic [STORE_BITS-1:0]                   least;
  msscan_pkg::status_t                     out_status;
  logic [msscan_pkg::VALUE_BITS-1:0]       out_value;

  msscan_pkg::op_t                         op;
  logic [msscan_pkg::VALUE_BITS-1:0]       value;
  logic                                    accept;
  logic                                    out_free;
  logic                                    full;
  logic                                    empty;
  logic                                    result_load;
  logic [CNT_BITS-1:0]                     count_dec;
  logic [STORE_BITS-1:0]                   least_next;

  // Unpack the input beat
  assign op    = msscan_pkg::op_t'(s_tdata[msscan_pkg::OP_LSB +: msscan_pkg::OP_BITS]);
  assign value = s_tdata[msscan_pkg::VALUE_LSB +: msscan_pkg::VALUE_BITS];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == CNT_BITS'(DEPTH));
  assign empty     = (count == '0);
  assign count_dec = count - 1'b1;

  // Load the result register on direct answers and at the end of a pop or scan
  assign result_load = (accept && !(((op == msscan_pkg::OP_POP) || (op == msscan_pkg::OP_MIN))
                                    && !empty))
                       || ((state == S_SEND) && out_free);

  // Keep the smaller of the running minimum and the word just read
  assign least_next = (rd_data < least) ? rd_data : least;

  // Push writes at the top; a read is only issued after that write has landed
  assign wr_addr       = count[ADDR_BITS-1:0];
  assign wr_data       = value[STORE_BITS-1:0];

  // Issue reads: top entry for pop, entry zero then upward for the scan
  always_comb begin
    mem_ctl.wr_en = accept && (op == msscan_pkg::OP_PUSH) && !full;
    mem_ctl.rd_en = 1'b0;
    rd_addr       = '0;
    case (state)
      S_IDLE: begin
        if (accept && !empty) begin
          if (op == msscan_pkg::OP_POP) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = count_dec[ADDR_BITS-1:0];
          end else if (op == msscan_pkg::OP_MIN) begin
            mem_ctl.rd_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (idx < count) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx[ADDR_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence the operations and hold the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (result_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              msscan_pkg::OP_PUSH: begin
                out_value <= '0;
                if (full) begin
                  out_status <= msscan_pkg::ST_FULL;
                end else begin
                  out_status <= msscan_pkg::ST_OK;
                  count      <= count + 1'b1;
                end
              end
              msscan_pkg::OP_POP: begin
                if (empty) begin
                  out_status <= msscan_pkg::ST_EMPTY;
                  out_value  <= '0;
                end else begin
                  count <= count_dec;
                  state <= S_POP_WAIT;
                end
              end
              msscan_pkg::OP_MIN: begin
                if (empty) begin
                  out_status <= msscan_pkg::ST_EMPTY;
                  out_value  <= '0;
                end else begin
                  idx   <= CNT_BITS'(1);
                  least <= '1;
                  state <= S_SCAN;
                end
              end
              default: begin
                // Unused code: answer ok with a zero word, stack untouched
                out_status <= msscan_pkg::ST_OK;
                out_value  <= '0;
              end
            endcase
          end
        end
        S_POP_WAIT: begin
          least <= rd_data;
          state <= S_SEND;
        end
        S_SCAN: begin
          least <= least_next;
          if (idx == count) begin
            state <= S_SEND;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_status <= msscan_pkg::ST_OK;
            out_value  <= msscan_pkg::VALUE_BITS'(least);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pack the result beat
  assign m_tdata = msscan_pkg::M_TDATA_BITS'({out_value, out_status});

endmodule

// ===== rtl/min_stack_scan.sv =====
// Push, unused codes and empty/full answers load the result register straight from the accept;
// a pop passes through S_POP_WAIT and S_SEND, a min scans its N held entries and then S_SEND.
// A new input beat is taken only once the previous op is back in S_IDLE; the min scan reads the
// entry memory one word per cycle through its single read port.
// A result waiting on m_tready holds off the next input beat only while it stalls.
// Reset (rst, synchronous) empties the stack; memory contents are not cleared.
`timescale 1ns / 1ps

module min_stack_scan #(
  parameter int DEPTH     = 128,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata, low bit up: op[1:0], value[33:2], zero pad[39:34]
  input  logic [msscan_pkg::S_TDATA_BITS-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata, low bit up: status[1:0], result_value[33:2], zero pad[39:34]
  output logic [msscan_pkg::M_TDATA_BITS-1:0] m_tdata
);

  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int STORE_BITS = (WORD_BITS < msscan_pkg::VALUE_BITS) ? WORD_BITS
                                                                   : msscan_pkg::VALUE_BITS;

  msscan_pkg::mem_ctl_t    mem_ctl;
  logic [ADDR_BITS-1:0]    wr_addr;
  logic [STORE_BITS-1:0]   wr_data;
  logic [ADDR_BITS-1:0]    rd_addr;
  logic [STORE_BITS-1:0]   rd_data;

  // Stack pointer, scan and result sequencing
  msscan_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_BITS  (WORD_BITS),
    .STORE_BITS (STORE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Stack entries
  msscan_ram #(
    .DEPTH (DEPTH),
    .WIDTH (STORE_BITS)
  ) u_ram (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/msscan_chk.sv =====
// Port-level checks for the minimum-tracking stack, bound to the top level.
`timescale 1ns / 1ps

module msscan_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [msscan_pkg::S_TDATA_BITS-1:0] s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [msscan_pkg::M_TDATA_BITS-1:0] m_tdata
);

  logic [msscan_pkg::STATUS_BITS-1:0] status;
  logic [msscan_pkg::VALUE_BITS-1:0]  result;

  assign status = m_tdata[msscan_pkg::STATUS_LSB +: msscan_pkg::STATUS_BITS];
  assign result = m_tdata[msscan_pkg::RESULT_LSB +: msscan_pkg::VALUE_BITS];

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result beat valid right after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // Error answers carry a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == msscan_pkg::ST_EMPTY || status == msscan_pkg::ST_FULL)
    |-> result == '0)
    else $error("error result carries a nonzero word");

  // No input beat is taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while result stalled");

endmodule

bind min_stack_scan msscan_chk u_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the min_stack_scan push/pop/minimum stack.
`timescale 1ns / 1ps

module testbench;

  localparam int STACK_DEPTH  = 128;
  localparam int WORD_W       = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = STACK_DEPTH + 16;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 120;
  localparam int PRINT_CAP    = 100;

  // Spare op code that the block answers with ok and zero
  localparam logic [msscan_pkg::OP_BITS-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [msscan_pkg::OP_BITS-1:0]     op;
    logic [msscan_pkg::STATUS_BITS-1:0] status;
    logic [msscan_pkg::VALUE_BITS-1:0]  value;
  } answer_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [msscan_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [msscan_pkg::M_TDATA_BITS-1:0] m_tdata;

  // Stack image kept in step with the accepted beats
  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  int unsigned       held_count;

  answer_t     pending_answers[$];
  answer_t     oldest_answer;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  logic        idle_on;

  min_stack_scan #(
    .DEPTH     (STACK_DEPTH),
    .WORD_BITS (WORD_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // End the run as failed once cycle_count reaches CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Apply one op to the stack image and return the answer it must give
  task automatic apply_stack_op(input logic [msscan_pkg::OP_BITS-1:0] op,
                                input logic [msscan_pkg::VALUE_BITS-1:0] value,
                                output answer_t answer);
    logic [WORD_W-1:0] least;
    answer.op     = op;
    answer.status = msscan_pkg::ST_OK;
    answer.value  = '0;
    case (op)
      msscan_pkg::OP_PUSH: begin
        if (held_count >= STACK_DEPTH) begin
          answer.status = msscan_pkg::ST_FULL;
        end else begin
          stack_words[held_count] = value[WORD_W-1:0];
          held_count++;
        end
      end
      msscan_pkg::OP_POP: begin
        if (held_count == 0) begin
          answer.status = msscan_pkg::ST_EMPTY;
        end else begin
          held_count--;
          answer.value = stack_words[held_count];
        end
      end
      msscan_pkg::OP_MIN: begin
        if (held_count == 0) begin
          answer.status = msscan_pkg::ST_EMPTY;
        end else begin
          least = '1;
          for (int i = 0; i < held_count; i++)
            if (stack_words[i] < least) least = stack_words[i];
          answer.value = least;
        end
      end
      default: ;
    endcase
  endtask

  // Send one beat, with an optional gap ahead of it, and log its answer
  task automatic send_op(input logic [msscan_pkg::OP_BITS-1:0] op,
                         input logic [msscan_pkg::VALUE_BITS-1:0] value);
    logic [msscan_pkg::S_TDATA_BITS-1:0] beat;
    answer_t                             answer;
    beat = '0;
    beat[msscan_pkg::OP_LSB +: msscan_pkg::OP_BITS]       = op;
    beat[msscan_pkg::VALUE_LSB +: msscan_pkg::VALUE_BITS] = value;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_stack_op(op, value, answer);
    pending_answers.push_back(answer);
  endtask

  // Mostly random words, with extremes and small values to force ties
  function automatic logic [msscan_pkg::VALUE_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return msscan_pkg::VALUE_BITS'($urandom_range(0, 15));
      3:       return ~msscan_pkg::VALUE_BITS'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Stall the result side in bursts while idling is on
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest pending answer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, tdata %h", m_tdata));
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (m_tdata[msscan_pkg::STATUS_LSB +: msscan_pkg::STATUS_BITS]
            !== oldest_answer.status)
          report_mismatch($sformatf("op %0d status %0d, want %0d", oldest_answer.op,
                                    m_tdata[msscan_pkg::STATUS_LSB +: msscan_pkg::STATUS_BITS],
                                    oldest_answer.status));
        if (m_tdata[msscan_pkg::RESULT_LSB +: msscan_pkg::VALUE_BITS]
            !== oldest_answer.value)
          report_mismatch($sformatf("op %0d result_value %h, want %h", oldest_answer.op,
                                    m_tdata[msscan_pkg::RESULT_LSB +: msscan_pkg::VALUE_BITS],
                                    oldest_answer.value));
      end
    end
  end

  // Empty-stack answers, spare code, extremes and a short push/pop run
  task automatic test_directed_edges();
    send_op(msscan_pkg::OP_MIN, $urandom);
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(OP_SPARE, $urandom);
    send_op(msscan_pkg::OP_PUSH, '1);
    send_op(msscan_pkg::OP_MIN, '0);
    send_op(msscan_pkg::OP_PUSH, '0);
    send_op(msscan_pkg::OP_MIN, '1);
    send_op(msscan_pkg::OP_PUSH, 32'hAAAA_AAAA);
    send_op(msscan_pkg::OP_PUSH, 32'h5555_5555);
    send_op(msscan_pkg::OP_PUSH, 32'h8000_0000);
    send_op(OP_SPARE, '1);
    send_op(msscan_pkg::OP_MIN, $urandom);
    send_op(msscan_pkg::OP_POP, '1);
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(msscan_pkg::OP_MIN, $urandom);
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(msscan_pkg::OP_MIN, $urandom);
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(msscan_pkg::OP_MIN, $urandom);
    send_op(OP_SPARE, '0);
  endtask

  // Fill to full, try pushes past the top, then drain past empty
  task automatic test_fill_and_drain();
    while (held_count < STACK_DEPTH) begin
      send_op(msscan_pkg::OP_PUSH, pick_word());
      if ($urandom_range(0, 15) == 0) send_op(msscan_pkg::OP_MIN, $urandom);
    end
    repeat (3) send_op(msscan_pkg::OP_PUSH, pick_word());
    send_op(msscan_pkg::OP_MIN, $urandom);
    send_op(OP_SPARE, $urandom);
    send_op(msscan_pkg::OP_PUSH, '0);
    while (held_count > 0) begin
      send_op(msscan_pkg::OP_POP, $urandom);
      if ($urandom_range(0, 15) == 0) send_op(msscan_pkg::OP_MIN, $urandom);
    end
    send_op(msscan_pkg::OP_POP, $urandom);
    send_op(msscan_pkg::OP_MIN, $urandom);
  endtask

  // Random mix in segments that lean toward growth, shrinkage or balance
  task automatic test_random_mix();
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned roll;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       begin push_pct = 70; pop_pct = 12; end
          1:       begin push_pct = 12; pop_pct = 70; end
          default: begin push_pct = 40; pop_pct = 38; end
        endcase
        if (n >= RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
        else idle_on <= ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < push_pct) send_op(msscan_pkg::OP_PUSH, pick_word());
      else if (roll < push_pct + pop_pct) send_op(msscan_pkg::OP_POP, $urandom);
      else if (roll < 97) send_op(msscan_pkg::OP_MIN, $urandom);
      else send_op(OP_SPARE, $urandom);
    end
  endtask

  initial begin
    held_count  = 0;
    error_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    idle_on     = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_fill_and_drain();
    test_random_mix();

    // Wait out the last answers, then the longest scan
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/msscan_pkg.sv
rtl/msscan_ram.sv
rtl/msscan_ctrl.sv
rtl/min_stack_scan.sv
rtl/msscan_chk.sv
tb/testbench.sv
